// ----- rtl/brq_pkg.sv -----
// Shared types and constants for the bit range update/query core.
`default_nettype none
package brq_pkg;

  // Bit array geometry: the array is stored as bytes
  localparam int CAPACITY = 1024;
  localparam int IDX_W    = 11;
  localparam int BYTE_W   = 8;
  localparam int NBYTES   = CAPACITY / BYTE_W;
  localparam int BADDR_W  = $clog2(NBYTES);
  localparam int BSEL_W   = $clog2(BYTE_W);
  localparam int CMD_W    = 4;

  // Command codes of the input word
  typedef enum logic [CMD_W-1:0] {
    CMD_SET     = 4'd0,
    CMD_FLIP    = 4'd1,
    CMD_AND     = 4'd2,
    CMD_OR      = 4'd3,
    CMD_XOR     = 4'd4,
    CMD_NAND    = 4'd5,
    CMD_NOR     = 4'd6,
    CMD_GET     = 4'd7,
    CMD_CNT1    = 4'd8,
    CMD_CNT0    = 4'd9,
    CMD_RUN1    = 4'd10,
    CMD_RUN0    = 4'd11,
    CMD_ANY     = 4'd12,
    CMD_ALL     = 4'd13,
    CMD_PARITY  = 4'd14
  } cmd_e;

  // Per-bit action applied by an update
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_CLR  = 2'd1,
    ACT_SETB = 2'd2,
    ACT_FLIP = 2'd3
  } act_e;

  // Configuration register indexes
  localparam logic [0:0] CFG_ACTIVE_LENGTH = 1'b0;
  localparam logic [0:0] CFG_INITIAL_FILL  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_DRAIN = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    logic             bit_operand;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] answer;
    logic             range_error;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic step;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk;
    logic last;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/brq_if.sv -----
// Valid/ready channel interfaces for input and result words.
`default_nettype none
interface brq_in_if import brq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface brq_out_if import brq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/bit_range_update_query_tree_core.sv -----
// Top level of the bit range update/query core.
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    cmd, left_index, right_index, bit_operand
//  out_ch    out  valid/ready    answer, range_error
//  cfg_*     in   cfg_wr_en      cfg_index, cfg_wdata
//
// A command that touches bits walks the bytes its range spans (up to 128);
// the byte store reads one byte per cycle, and an update writes back the byte
// read the cycle before.
// A command with an invalid or empty range, or without effect, skips the byte walk.
// Synchronous active-low reset; no clearing pass, written flags mark the bytes.
// A new word is taken while the previous result waits in the output register.
`default_nettype none
module bit_range_update_query_tree_core import brq_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  brq_in_if.sink                in_ch,
  brq_out_if.source             out_ch,
  input  wire logic             cfg_wr_en,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [IDX_W-1:0] cfg_wdata
);

  ctrl_cmd_t ccmd;
  dp_stat_t  stat;

  brq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (ccmd)
  );

  brq_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_ch.data),
    .cmd       (ccmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data)
  );

endmodule
`default_nettype wire

// ----- rtl/brq_ctrl.sv -----
// Sequencer for one command: accept, byte walk, drain, deliver.
`default_nettype none
module brq_ctrl import brq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  state_e state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = stat.walk ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/brq_dpath.sv -----
// Bit store, range decode, byte walker with run tracking, result register.
`default_nettype none
module brq_dpath import brq_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [IDX_W-1:0] cfg_wdata,
  input  wire in_item_t         in_data,
  input  wire ctrl_cmd_t        cmd,
  output dp_stat_t              stat,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output out_item_t             out_data
);

  // Configuration
  logic [IDX_W-1:0] len_r;
  logic             fill_r;
  logic [IDX_W-1:0] cfg_len;

  // Byte store with per-byte written flags
  logic [BYTE_W-1:0]  mem [NBYTES];
  logic [NBYTES-1:0]  vld_r;

  // Command context
  logic [CMD_W-1:0]   cmd_r;
  logic [IDX_W-1:0]   l_r, r_r;
  act_e               act_r;
  logic               err_r;
  logic [BADDR_W-1:0] addr_r, hb_r;

  // Process stage
  logic               s2_r;
  logic [BADDR_W-1:0] paddr_r;
  logic               pvld_r;
  logic [BYTE_W-1:0]  rdata_r;

  // Accumulators
  logic [IDX_W-1:0] ones_r, cur1_r, cur0_r, best1_r, best0_r;
  logic [IDX_W-1:0] ones_nxt, cur1_nxt, cur0_nxt, best1_nxt, best0_nxt;

  // Result register
  logic      out_valid_r;
  out_item_t out_data_r;

  // Decode of the incoming word
  logic             dec_err, dec_walk, range_bad;
  act_e             dec_act;
  logic [IDX_W-1:0] dec_r, dec_rm1;
  logic [IDX_W-1:0] in_l, in_r;
  logic             in_f;

  assign in_l      = in_data.left_index;
  assign in_r      = in_data.right_index;
  assign in_f      = in_data.bit_operand;
  assign range_bad = (in_l > in_r) || (in_r > len_r);

  always_comb begin
    dec_err  = 1'b0;
    dec_act  = ACT_NONE;
    dec_walk = 1'b0;
    dec_r    = in_r;
    priority if (in_data.cmd <= CMD_NOR) begin
      dec_err = range_bad;
      unique case (in_data.cmd)
        CMD_SET:  dec_act = in_f ? ACT_SETB : ACT_CLR;
        CMD_FLIP: dec_act = ACT_FLIP;
        CMD_AND:  dec_act = in_f ? ACT_NONE : ACT_CLR;
        CMD_OR:   dec_act = in_f ? ACT_SETB : ACT_NONE;
        CMD_XOR:  dec_act = in_f ? ACT_FLIP : ACT_NONE;
        CMD_NAND: dec_act = in_f ? ACT_FLIP : ACT_SETB;
        default:  dec_act = in_f ? ACT_CLR : ACT_FLIP;
      endcase
      dec_walk = !range_bad && (dec_act != ACT_NONE) && (in_l < in_r);
    end else if (in_data.cmd == CMD_GET) begin
      dec_err  = (in_l >= len_r);
      dec_r    = in_l + 1'b1;
      dec_walk = !dec_err;
    end else if (in_data.cmd <= CMD_PARITY) begin
      dec_err  = range_bad || ((in_data.cmd >= CMD_ANY) && (in_l == in_r));
      dec_walk = !dec_err && (in_l < in_r);
    end else begin
      dec_err  = 1'b0;
    end
  end

  assign dec_rm1 = dec_r - 1'b1;

  // Saturated active length from the write data
  always_comb begin
    priority if (cfg_wdata == '0) begin
      cfg_len = IDX_W'(1);
    end else if (cfg_wdata > IDX_W'(CAPACITY)) begin
      cfg_len = IDX_W'(CAPACITY);
    end else begin
      cfg_len = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= IDX_W'(CAPACITY);
      fill_r <= 1'b0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_ACTIVE_LENGTH) begin
        len_r <= cfg_len;
      end else begin
        fill_r <= cfg_wdata[0];
      end
    end
  end

  // Context capture and byte address walk
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r  <= in_data.cmd;
      l_r    <= in_l;
      r_r    <= dec_r;
      act_r  <= dec_act;
      err_r  <= dec_err;
      addr_r <= in_l[BSEL_W +: BADDR_W];
      hb_r   <= dec_rm1[BSEL_W +: BADDR_W];
    end else if (cmd.step) begin
      addr_r <= addr_r + 1'b1;
    end
  end

  assign stat.walk     = dec_walk;
  assign stat.last     = (addr_r == hb_r);
  assign stat.out_busy = out_valid_r && !out_ready;

  // Registered read of the store
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rdata_r <= mem[addr_r];
      pvld_r  <= vld_r[addr_r];
      paddr_r <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= 1'b0;
    end else begin
      s2_r <= cmd.step;
    end
  end

  // Byte processing: mask, update value, counts and runs
  logic [BYTE_W-1:0] old_b, mask_b, new_b, set_b;
  logic [BSEL_W:0]   pc;
  logic              wr_en;

  always_comb begin
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] c1, c0, b1, b0;
    old_b = pvld_r ? rdata_r : {BYTE_W{fill_r}};
    pc    = '0;
    c1    = cur1_r;
    c0    = cur0_r;
    b1    = best1_r;
    b0    = best0_r;
    for (int i = 0; i < BYTE_W; i++) begin
      pos       = IDX_W'({paddr_r, BSEL_W'(i)});
      mask_b[i] = (pos >= l_r) && (pos < r_r);
    end
    for (int i = 0; i < BYTE_W; i++) begin
      if (mask_b[i]) begin
        if (old_b[i]) begin
          pc = pc + 1'b1;
          c1 = c1 + 1'b1;
          c0 = '0;
          if (c1 > b1) b1 = c1;
        end else begin
          c0 = c0 + 1'b1;
          c1 = '0;
          if (c0 > b0) b0 = c0;
        end
      end
    end
    cur1_nxt  = c1;
    cur0_nxt  = c0;
    best1_nxt = b1;
    best0_nxt = b0;
    ones_nxt  = ones_r + IDX_W'(pc);
    unique case (act_r)
      ACT_CLR:  set_b = '0;
      ACT_SETB: set_b = '1;
      ACT_FLIP: set_b = ~old_b;
      default:  set_b = old_b;
    endcase
    new_b = (old_b & ~mask_b) | (set_b & mask_b);
  end

  assign wr_en = s2_r && (act_r != ACT_NONE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[paddr_r] <= new_b;
    end
  end

  // Written flags: a refill clears them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cfg_wr_en) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[paddr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ones_r  <= '0;
      cur1_r  <= '0;
      cur0_r  <= '0;
      best1_r <= '0;
      best0_r <= '0;
    end else if (s2_r) begin
      ones_r  <= ones_nxt;
      cur1_r  <= cur1_nxt;
      cur0_r  <= cur0_nxt;
      best1_r <= best1_nxt;
      best0_r <= best0_nxt;
    end
  end

  // Answer selection
  logic [IDX_W-1:0] span, ans;
  assign span = r_r - l_r;

  always_comb begin
    ans = '0;
    if (!err_r) begin
      unique case (cmd_r)
        CMD_GET,
        CMD_CNT1:   ans = ones_r;
        CMD_CNT0:   ans = span - ones_r;
        CMD_RUN1:   ans = best1_r;
        CMD_RUN0:   ans = best0_r;
        CMD_ANY:    ans = IDX_W'(ones_r != '0);
        CMD_ALL:    ans = IDX_W'(ones_r == span);
        CMD_PARITY: ans = IDX_W'(ones_r[0]);
        default:    ans = '0;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.answer      <= ans;
      out_data_r.range_error <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_refill_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (vld_r == '0))
    else $error("written flags not cleared by a configuration write");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r >= IDX_W'(1)) && (len_r <= IDX_W'(CAPACITY)))
    else $error("active length out of range");

  a_start_no_proc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !s2_r)
    else $error("byte processed right after a command start");

endmodule
`default_nettype wire

// ----- tb/brq_checker.sv -----
// Checker for the bit range core: mirrors the bit array and compares result words.
`default_nettype none
module brq_checker import brq_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  brq_in_if                     in_ch,
  brq_out_if                    out_ch,
  input  wire logic             cfg_wr_en,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [IDX_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  bit [CAPACITY-1:0] bit_array;
  int                used_bits;
  bit                fill_bit;
  out_item_t         answer_q[$];

  // Print one mismatch line and count it
  task automatic report(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Refill every bit with the fill value
  function automatic void refill();
    bit_array = fill_bit ? '1 : '0;
  endfunction

  // Work out the result of one command and apply its updates
  function automatic out_item_t apply_command(in_item_t w);
    out_item_t res;
    act_e act;
    int l, r, ones, run1, run0, best1, best0;
    res = '0;
    act = ACT_NONE;
    l = int'(w.left_index);
    r = int'(w.right_index);
    if (w.cmd <= CMD_NOR) begin
      if (l > r || r > used_bits) begin
        res.range_error = 1'b1;
      end else begin
        case (w.cmd)
          CMD_SET:  act = w.bit_operand ? ACT_SETB : ACT_CLR;
          CMD_FLIP: act = ACT_FLIP;
          CMD_AND:  act = w.bit_operand ? ACT_NONE : ACT_CLR;
          CMD_OR:   act = w.bit_operand ? ACT_SETB : ACT_NONE;
          CMD_XOR:  act = w.bit_operand ? ACT_FLIP : ACT_NONE;
          CMD_NAND: act = w.bit_operand ? ACT_FLIP : ACT_SETB;
          default:  act = w.bit_operand ? ACT_CLR : ACT_FLIP;
        endcase
        for (int i = l; i < r; i++) begin
          case (act)
            ACT_CLR:  bit_array[i] = 1'b0;
            ACT_SETB: bit_array[i] = 1'b1;
            ACT_FLIP: bit_array[i] = ~bit_array[i];
            default: ;
          endcase
        end
      end
    end else if (w.cmd == CMD_GET) begin
      if (l >= used_bits) res.range_error = 1'b1;
      else res.answer = IDX_W'(bit_array[l]);
    end else if (w.cmd <= CMD_PARITY) begin
      if (l > r || r > used_bits || (w.cmd >= CMD_ANY && l == r)) begin
        res.range_error = 1'b1;
      end else begin
        ones = 0; run1 = 0; run0 = 0; best1 = 0; best0 = 0;
        for (int i = l; i < r; i++) begin
          if (bit_array[i]) begin
            ones++; run1++; run0 = 0;
          end else begin
            run0++; run1 = 0;
          end
          if (run1 > best1) best1 = run1;
          if (run0 > best0) best0 = run0;
        end
        case (w.cmd)
          CMD_CNT1: res.answer = IDX_W'(ones);
          CMD_CNT0: res.answer = IDX_W'((r - l) - ones);
          CMD_RUN1: res.answer = IDX_W'(best1);
          CMD_RUN0: res.answer = IDX_W'(best0);
          CMD_ANY:  res.answer = IDX_W'(ones > 0);
          CMD_ALL:  res.answer = IDX_W'(ones == r - l);
          default:  res.answer = IDX_W'(ones[0]);
        endcase
      end
    end
    return res;
  endfunction

  // Watch configuration, input and result channels
  always @(posedge clk) begin
    out_item_t want;
    int v;
    if (!rst_n) begin
      used_bits = CAPACITY;
      fill_bit = 1'b0;
      refill();
      answer_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_ACTIVE_LENGTH) begin
          v = int'(cfg_wdata);
          used_bits = v < 1 ? 1 : (v > CAPACITY ? CAPACITY : v);
        end else begin
          fill_bit = cfg_wdata[0];
        end
        refill();
      end
      if (in_ch.valid && in_ch.ready) answer_q.push_back(apply_command(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          report("unexpected word", int'(out_ch.data.answer), -1);
        end else begin
          want = answer_q.pop_front();
          if (out_ch.data.answer !== want.answer)
            report("answer", int'(out_ch.data.answer), int'(want.answer));
          if (out_ch.data.range_error !== want.range_error)
            report("range_error", int'(out_ch.data.range_error),
                   int'(want.range_error));
        end
      end
    end
    pending = answer_q.size();
  end
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench top: clock, reset, stimulus, receiver stalls and verdict.
`default_nettype none
module tb;
  import brq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [0:0]       cfg_index = CFG_ACTIVE_LENGTH;
  logic [IDX_W-1:0] cfg_wdata = '0;
  int               fail_count, pending;
  int               used_bits = CAPACITY;
  bit               hold_req = 1'b0;

  brq_in_if  in_ch();
  brq_out_if out_ch();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always #6 clk = ~clk;

  bit_range_update_query_tree_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata));

  brq_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending));

  // Offer one word and hold it until taken; leaves valid high
  task automatic send_word(input logic [CMD_W-1:0] c, input int l, input int r,
                           input bit b);
    in_ch.valid <= 1'b1;
    in_ch.data <= '{cmd: c, left_index: l[IDX_W-1:0], right_index: r[IDX_W-1:0],
                    bit_operand: b};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and idle the sender; does nothing when n is zero
  task automatic idle_for(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Wait for all results, let the core settle, then write a register
  task automatic write_reg(input logic [0:0] idx, input int val);
    idle_for(1);
    while (pending != 0) @(negedge clk);
    repeat (140) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[IDX_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_ACTIVE_LENGTH)
      used_bits = val < 1 ? 1 : (val > CAPACITY ? CAPACITY : val);
  endtask

  // One random word: mostly valid ranges with short spans, some noise
  task automatic random_word();
    logic [CMD_W-1:0] c;
    int l, r, span;
    c = ($urandom_range(0, 40) == 0) ? 4'hF : 4'($urandom_range(0, 14));
    if ($urandom_range(0, 9) < 8) begin
      l = $urandom_range(0, used_bits);
      span = ($urandom_range(0, 15) == 0) ? used_bits : $urandom_range(0, 48);
      r = l + $urandom_range(0, span);
      if (r > used_bits) r = used_bits;
      if ($urandom_range(0, 19) == 0) begin
        l = 0; r = used_bits;
      end
      if (c == CMD_GET && l >= used_bits) l = used_bits - 1;
    end else begin
      l = $urandom_range(0, 2047);
      r = $urandom_range(0, 2047);
    end
    send_word(c, l, r, $urandom_range(0, 1));
  endtask

  // Random phase in bursts with gaps; optional long receiver hold-off
  task automatic random_phase(input int count, input bit with_hold);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      if (with_hold && count < 150 && !hold_req) begin
        hold_req = 1'b1;
        with_hold = 1'b0;
      end
      repeat (burst) begin
        if (count > 0) begin
          random_word();
          count--;
        end
      end
      idle_for($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
    end
  endtask

  // Receiver: stalls on a pattern that changes per stretch, plus long hold-offs
  initial begin
    int mode, left_in_mode, hold;
    mode = 0;
    left_in_mode = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(negedge clk);
        hold_req = 1'b0;
      end
      if (left_in_mode == 0) begin
        mode = $urandom_range(0, 2);
        left_in_mode = $urandom_range(20, 200);
      end
      left_in_mode--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Stimulus
  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, every command, error and empty cases
    send_word(CMD_SET, 0, CAPACITY, 1'b1);
    send_word(CMD_GET, 0, 0, 1'b0);
    send_word(CMD_GET, CAPACITY - 1, 0, 1'b0);
    send_word(CMD_GET, CAPACITY, 0, 1'b0);
    send_word(CMD_FLIP, 100, 300, 1'b0);
    send_word(CMD_AND, 500, 520, 1'b0);
    send_word(CMD_OR, 200, 210, 1'b1);
    send_word(CMD_XOR, 0, 5, 1'b1);
    send_word(CMD_NAND, 700, 900, 1'b1);
    send_word(CMD_NAND, 1000, 1010, 1'b0);
    send_word(CMD_NOR, 10, 20, 1'b0);
    send_word(CMD_NOR, 30, 40, 1'b1);
    send_word(CMD_CNT1, 0, CAPACITY, 1'b0);
    send_word(CMD_CNT0, 0, CAPACITY, 1'b0);
    send_word(CMD_RUN1, 0, CAPACITY, 1'b0);
    send_word(CMD_RUN0, 0, CAPACITY, 1'b0);
    send_word(CMD_ANY, 100, 300, 1'b0);
    send_word(CMD_ALL, 300, 700, 1'b0);
    send_word(CMD_PARITY, 3, 998, 1'b0);
    send_word(CMD_ANY, 50, 50, 1'b0);
    send_word(CMD_CNT1, 50, 50, 1'b0);
    send_word(CMD_SET, 60, 60, 1'b1);
    send_word(CMD_CNT1, 9, 8, 1'b0);
    send_word(CMD_FLIP, 0, CAPACITY + 1, 1'b0);
    send_word(4'hF, 2047, 2047, 1'b1);

    // Sender pause until everything is back
    idle_for(1);
    while (pending != 0) @(negedge clk);

    random_phase(300, 1'b1);
    write_reg(CFG_ACTIVE_LENGTH, 1);
    write_reg(CFG_INITIAL_FILL, 1);
    random_phase(100, 1'b0);
    write_reg(CFG_ACTIVE_LENGTH, 37);
    random_phase(300, 1'b0);
    write_reg(CFG_INITIAL_FILL, 0);
    write_reg(CFG_ACTIVE_LENGTH, 0);
    random_phase(60, 1'b0);
    write_reg(CFG_ACTIVE_LENGTH, 2047);
    write_reg(CFG_INITIAL_FILL, 1);
    random_phase(300, 1'b1);
    write_reg(CFG_ACTIVE_LENGTH, 200);
    random_phase(340, 1'b0);

    // Drain
    idle_for(1);
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Run limit
  initial begin
    #48ms;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
